/* rtl/rbd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbd_pkg: shared types and constants of the run-length block decoder
// Field widths, parser phase codes and the stream signature bytes.
// ----------------------------------------------------------------------------
package rbd_pkg;

  // largest unit size in bytes
  localparam int unsigned MAX_UNIT_BYTES = 8;

  // field widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned UNIT_W   = MAX_UNIT_BYTES * BYTE_W;
  localparam int unsigned UB_W     = 4;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned POS_W    = 3;
  localparam int unsigned HPOS_W   = 2;

  // input item kinds
  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  // result status codes
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_BAD_SIG = 1'b1;

  // control byte layout
  localparam int unsigned REPEAT_BIT = 7;

  // index of the last signature byte
  localparam logic [HPOS_W-1:0] SIG_LAST = 2'd2;

  // parser phases
  typedef enum logic [2:0] {
    PH_HEADER,
    PH_CONTROL,
    PH_RUN,
    PH_LITERAL,
    PH_FAILED
  } phase_e;

  // signature "cre", one byte per header position
  function automatic logic [BYTE_W-1:0] sig_byte(logic [HPOS_W-1:0] idx);
    logic [BYTE_W-1:0] b;
    case (idx)
      2'd0:    b = 8'h63;
      2'd1:    b = 8'h72;
      default: b = 8'h65;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

/* rtl/rbd_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbd_in_if: compressed byte channel
// Valid/ready channel that carries one stream byte or a restart per item.
// ----------------------------------------------------------------------------
interface rbd_in_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [rbd_pkg::BYTE_W-1:0]  byte_value;

  modport source (output valid, output kind, output byte_value, input ready);
  modport sink   (input valid, input kind, input byte_value, output ready);
endinterface
`default_nettype wire

/* rtl/rbd_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbd_out_if: decoded unit channel
// Valid/ready channel that carries one decoded unit or an error per item.
// ----------------------------------------------------------------------------
interface rbd_out_if;
  logic                         valid;
  logic                         ready;
  logic [rbd_pkg::UNIT_W-1:0]   unit_value;
  logic [rbd_pkg::UB_W-1:0]     unit_length;
  logic [rbd_pkg::COUNT_W-1:0]  repeat_count;
  logic                         status;

  modport source (output valid, output unit_value, output unit_length,
                  output repeat_count, output status, input ready);
  modport sink   (input valid, input unit_value, input unit_length,
                  input repeat_count, input status, output ready);
endinterface
`default_nettype wire

/* rtl/rle_block_decoder.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rle_block_decoder: run-length block decoder
// Checks the stream signature, parses control bytes and gathers units of
// unit_bytes bytes; emits literal units and nonzero runs with repeat counts.
// ----------------------------------------------------------------------------
// Result: registered; it shows on the output in the cycle after the byte that
//   completes its unit (or the last byte of a bad signature) is accepted.
// Throughput: one item per cycle; the output register lets the next item in
//   while a result waits, as long as that slot is taken in the same cycle.
// Reset: asynchronous, active low; parser returns to the header phase and
//   unit_bytes to 1. Restart items reset the parser but keep unit_bytes.
module rle_block_decoder (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [rbd_pkg::UB_W-1:0]   cfg_wdata_i,
  rbd_in_if.sink                          in_i,
  rbd_out_if.source                       out_o
);

  // configuration register
  logic [rbd_pkg::UB_W-1:0] unit_bytes_q;

  // parser state
  rbd_pkg::phase_e                phase_q, phase_d;
  logic [rbd_pkg::HPOS_W-1:0]     header_pos_q, header_pos_d;
  logic                           header_ok_q, header_ok_d;
  logic [rbd_pkg::COUNT_W-1:0]    units_left_q, units_left_d;
  logic [rbd_pkg::COUNT_W-1:0]    run_count_q, run_count_d;
  logic [rbd_pkg::POS_W-1:0]      byte_pos_q, byte_pos_d;
  logic [rbd_pkg::UNIT_W-1:0]     gather_q, gather_d;

  // result register
  logic                           out_vld_q, out_vld_d;
  logic [rbd_pkg::UNIT_W-1:0]     out_value_q, out_value_d;
  logic [rbd_pkg::UB_W-1:0]       out_len_q, out_len_d;
  logic [rbd_pkg::COUNT_W-1:0]    out_rep_q, out_rep_d;
  logic                           out_status_q, out_status_d;

  logic                           in_acc;
  logic                           is_data;
  logic [rbd_pkg::UB_W-1:0]       ub_eff;
  logic [rbd_pkg::UB_W-1:0]       pos_inc;
  logic                           unit_done;
  logic [rbd_pkg::UNIT_W-1:0]     gather_new;
  logic [rbd_pkg::HPOS_W-1:0]     hp;
  logic                           sig_match;
  logic [rbd_pkg::COUNT_W-1:0]    ctrl_cnt;
  logic                           ctrl_rep;

  // handshake: take a new item whenever the result slot frees up
  assign in_i.ready = !out_vld_q || out_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;
  assign is_data    = in_acc && (in_i.kind == rbd_pkg::KIND_DATA);

  // unit size clamped to 1..MAX_UNIT_BYTES
  always_comb begin
    if (unit_bytes_q == '0) begin
      ub_eff = rbd_pkg::UB_W'(1);
    end else if (unit_bytes_q > rbd_pkg::UB_W'(rbd_pkg::MAX_UNIT_BYTES)) begin
      ub_eff = rbd_pkg::UB_W'(rbd_pkg::MAX_UNIT_BYTES);
    end else begin
      ub_eff = unit_bytes_q;
    end
  end

  // byte gathering into the current unit
  assign pos_inc    = {1'b0, byte_pos_q} + rbd_pkg::UB_W'(1);
  assign unit_done  = pos_inc >= ub_eff;
  assign gather_new = gather_q
                    | (rbd_pkg::UNIT_W'(in_i.byte_value) << {byte_pos_q, 3'b000});

  // signature compare and control byte fields
  assign hp        = (header_pos_q > rbd_pkg::SIG_LAST) ? rbd_pkg::SIG_LAST : header_pos_q;
  assign sig_match = in_i.byte_value == rbd_pkg::sig_byte(hp);
  assign ctrl_cnt  = in_i.byte_value[rbd_pkg::COUNT_W-1:0];
  assign ctrl_rep  = in_i.byte_value[rbd_pkg::REPEAT_BIT];

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (in_acc && (in_i.kind == rbd_pkg::KIND_RESTART)) begin
      phase_d = rbd_pkg::PH_HEADER;
    end else if (is_data) begin
      case (phase_q)
        rbd_pkg::PH_HEADER: begin
          if (hp == rbd_pkg::SIG_LAST) begin
            phase_d = (header_ok_q && sig_match) ? rbd_pkg::PH_CONTROL
                                                 : rbd_pkg::PH_FAILED;
          end
        end
        rbd_pkg::PH_CONTROL: begin
          if (ctrl_rep) begin
            phase_d = rbd_pkg::PH_RUN;
          end else if (ctrl_cnt != '0) begin
            phase_d = rbd_pkg::PH_LITERAL;
          end
        end
        rbd_pkg::PH_RUN: begin
          if (unit_done) phase_d = rbd_pkg::PH_CONTROL;
        end
        rbd_pkg::PH_LITERAL: begin
          if (unit_done && (units_left_q == rbd_pkg::COUNT_W'(1))) begin
            phase_d = rbd_pkg::PH_CONTROL;
          end
        end
        rbd_pkg::PH_FAILED: phase_d = rbd_pkg::PH_FAILED;
        default:            phase_d = rbd_pkg::PH_FAILED;
      endcase
    end
  end

  // datapath and result
  always_comb begin
    header_pos_d = header_pos_q;
    header_ok_d  = header_ok_q;
    units_left_d = units_left_q;
    run_count_d  = run_count_q;
    byte_pos_d   = byte_pos_q;
    gather_d     = gather_q;
    out_vld_d    = out_vld_q && !out_o.ready;
    out_value_d  = out_value_q;
    out_len_d    = out_len_q;
    out_rep_d    = out_rep_q;
    out_status_d = out_status_q;

    if (in_acc && (in_i.kind == rbd_pkg::KIND_RESTART)) begin
      header_pos_d = '0;
      header_ok_d  = 1'b1;
      units_left_d = '0;
      run_count_d  = '0;
      byte_pos_d   = '0;
      gather_d     = '0;
    end else if (is_data) begin
      case (phase_q)
        rbd_pkg::PH_HEADER: begin
          header_ok_d = header_ok_q && sig_match;
          if (hp == rbd_pkg::SIG_LAST) begin
            header_pos_d = '0;
            if (!(header_ok_q && sig_match)) begin
              out_vld_d    = 1'b1;
              out_value_d  = '0;
              out_len_d    = '0;
              out_rep_d    = '0;
              out_status_d = rbd_pkg::STATUS_BAD_SIG;
            end
          end else begin
            header_pos_d = hp + rbd_pkg::HPOS_W'(1);
          end
        end
        rbd_pkg::PH_CONTROL: begin
          gather_d   = '0;
          byte_pos_d = '0;
          if (ctrl_rep) begin
            run_count_d = ctrl_cnt;
          end else if (ctrl_cnt != '0) begin
            units_left_d = ctrl_cnt;
          end
        end
        rbd_pkg::PH_RUN: begin
          if (unit_done) begin
            byte_pos_d = '0;
            gather_d   = '0;
            if (run_count_q != '0) begin
              out_vld_d    = 1'b1;
              out_value_d  = gather_new;
              out_len_d    = ub_eff;
              out_rep_d    = run_count_q;
              out_status_d = rbd_pkg::STATUS_OK;
            end
          end else begin
            byte_pos_d = pos_inc[rbd_pkg::POS_W-1:0];
            gather_d   = gather_new;
          end
        end
        rbd_pkg::PH_LITERAL: begin
          if (unit_done) begin
            byte_pos_d   = '0;
            gather_d     = '0;
            units_left_d = units_left_q - rbd_pkg::COUNT_W'(1);
            out_vld_d    = 1'b1;
            out_value_d  = gather_new;
            out_len_d    = ub_eff;
            out_rep_d    = rbd_pkg::COUNT_W'(1);
            out_status_d = rbd_pkg::STATUS_OK;
          end else begin
            byte_pos_d = pos_inc[rbd_pkg::POS_W-1:0];
            gather_d   = gather_new;
          end
        end
        default: begin
          // failed stream: bytes are dropped until restart
        end
      endcase
    end
  end

  // state and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_bytes_q <= rbd_pkg::UB_W'(1);
      phase_q      <= rbd_pkg::PH_HEADER;
      header_pos_q <= '0;
      header_ok_q  <= 1'b1;
      units_left_q <= '0;
      run_count_q  <= '0;
      byte_pos_q   <= '0;
      gather_q     <= '0;
      out_vld_q    <= 1'b0;
    end else begin
      if (cfg_we_i) unit_bytes_q <= cfg_wdata_i;
      phase_q      <= phase_d;
      header_pos_q <= header_pos_d;
      header_ok_q  <= header_ok_d;
      units_left_q <= units_left_d;
      run_count_q  <= run_count_d;
      byte_pos_q   <= byte_pos_d;
      gather_q     <= gather_d;
      out_vld_q    <= out_vld_d;
    end
  end

  // result payload, no reset
  always_ff @(posedge clk_i) begin
    out_value_q  <= out_value_d;
    out_len_q    <= out_len_d;
    out_rep_q    <= out_rep_d;
    out_status_q <= out_status_d;
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.unit_value   = out_value_q;
  assign out_o.unit_length  = out_len_q;
  assign out_o.repeat_count = out_rep_q;
  assign out_o.status       = out_status_q;

  // checks
  a_err_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (out_status_q == rbd_pkg::STATUS_BAD_SIG))
      |-> (out_len_q == '0) && (out_rep_q == '0) && (out_value_q == '0))
    else $error("error result carries unit data");

  a_fail_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == rbd_pkg::PH_FAILED) |-> !header_ok_q)
    else $error("failed phase with signature marked good");

  a_lit_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == rbd_pkg::PH_LITERAL) |-> (units_left_q != '0))
    else $error("literal phase with no units left");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_i.kind == rbd_pkg::KIND_RESTART))
      |=> (phase_q == rbd_pkg::PH_HEADER) && (header_pos_q == '0) && header_ok_q)
    else $error("restart did not reset the parser");

endmodule
`default_nettype wire
